[src/tsac_pkg.sv]
// Package for the touch sample averaging and calibration block.
// Holds widths, spans, register indexes, the state enum and control structs.
// No dependencies.
package tsac_pkg;

  localparam int SAMPLES_DEFAULT = 16;

  localparam int FRAME_W  = 16;
  localparam int SAMPLE_W = 13;
  localparam int SUM_W    = 17;
  localparam int SCR_W    = 9;
  localparam int PROD_W   = SAMPLE_W + SCR_W;
  localparam int DIV_STEPS = SCR_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int AVG_SHIFT = 4;

  localparam logic [SCR_W-1:0] X_SPAN = SCR_W'(239);
  localparam logic [SCR_W-1:0] Y_SPAN = SCR_W'(319);

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_CAL_MIN  = 3'd0,
    REG_X_CAL_MAX  = 3'd1,
    REG_Y_CAL_MIN  = 3'd2,
    REG_Y_CAL_MAX  = 3'd3,
    REG_LANDSCAPE  = 3'd4
  } tsac_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } tsac_state_t;

  // Control shared by both lanes.
  typedef struct packed {
    logic acc;   // add a pen-down sample pair
    logic last;  // this pair closes the burst
    logic clr;   // pen up: drop the burst
    logic mul;   // clamp check and scale product
    logic step;  // one restoring-division step
  } tsac_lane_ctrl_t;

  // Control for the output stage.
  typedef struct packed {
    logic load_zero;
    logic load_calc;
  } tsac_out_ctrl_t;

endpackage

[src/tsac_lane.sv]
// One axis lane: saturating accumulator, average, clamp and sequential scaler.
// Depends on tsac_pkg.
module tsac_lane
  import tsac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tsac_lane_ctrl_t     ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [SAMPLE_W-1:0] cal_min,
  input  logic [SAMPLE_W-1:0] cal_max,
  input  logic [SCR_W-1:0]    span,
  output logic [SAMPLE_W-1:0] avg,
  output logic [SCR_W-1:0]    scaled
);

  logic [SUM_W-1:0]    sum;
  logic [SUM_W:0]      sum_wide;
  logic [SUM_W-1:0]    sum_sat;
  logic                clamp_lo;
  logic                clamp_hi;
  logic [PROD_W-1:0]   rem;
  logic [PROD_W-1:0]   den_sh;
  logic [SCR_W-1:0]    quo;
  logic [SAMPLE_W-1:0] diff;
  logic                fits;

  assign sum_wide = {1'b0, sum} + (SUM_W+1)'(sample);
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign diff     = avg - cal_min;
  assign fits     = rem >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.clr || (ctrl.acc && ctrl.last)) begin
      sum <= '0;
    end else if (ctrl.acc) begin
      sum <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc && ctrl.last) begin
      avg <= sum_sat[AVG_SHIFT +: SAMPLE_W];
    end
    if (ctrl.mul) begin
      clamp_lo <= avg <= cal_min;
      clamp_hi <= avg >= cal_max;
      rem      <= PROD_W'(diff) * PROD_W'(span);
      den_sh   <= PROD_W'(cal_max - cal_min) << (DIV_STEPS - 1);
      quo      <= '0;
    end else if (ctrl.step) begin
      if (fits) begin
        rem <= rem - den_sh;
      end
      den_sh <= den_sh >> 1;
      quo    <= {quo[SCR_W-2:0], fits};
    end
  end

  always_comb begin
    priority if (clamp_lo) begin
      scaled = '0;
    end else if (clamp_hi) begin
      scaled = span;
    end else begin
      scaled = quo;
    end
  end

endmodule

[src/tsac_merge.sv]
// Merge stage: combines both lanes, applies the zero and landscape rules,
// and holds the output register. Depends on tsac_pkg.
module tsac_merge
  import tsac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  tsac_out_ctrl_t      ctrl,
  input  logic                landscape,
  input  logic [SAMPLE_W-1:0] lane_avg_x,
  input  logic [SAMPLE_W-1:0] lane_avg_y,
  input  logic [SCR_W-1:0]    lane_scr_x,
  input  logic [SCR_W-1:0]    lane_scr_y,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] avg_x,
  output logic [SAMPLE_W-1:0] avg_y,
  output logic [SCR_W-1:0]    screen_x,
  output logic [SCR_W-1:0]    screen_y
);

  logic [SAMPLE_W-1:0] ax_m;
  logic [SAMPLE_W-1:0] ay_m;
  logic [SCR_W-1:0]    sx_m;
  logic [SCR_W-1:0]    sy_m;
  logic [SCR_W-1:0]    sy_port;

  assign sy_port = Y_SPAN - lane_scr_y;

  always_comb begin
    ax_m = lane_avg_x;
    ay_m = lane_avg_y;
    sx_m = lane_scr_x;
    sy_m = sy_port;
    priority if (lane_avg_x == '0 && lane_avg_y == '0) begin
      sx_m = '0;
      sy_m = '0;
    end else if (landscape) begin
      // rotate: swap the averages, X takes inverted Y, Y takes mirrored X
      ax_m = lane_avg_y;
      ay_m = lane_avg_x;
      sx_m = sy_port;
      sy_m = X_SPAN - lane_scr_x;
    end else begin
      // portrait: keep the averages and the X result, Y takes inverted Y
      ax_m = lane_avg_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_zero || ctrl.load_calc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_zero) begin
      avg_x    <= '0;
      avg_y    <= '0;
      screen_x <= '0;
      screen_y <= '0;
    end else if (ctrl.load_calc) begin
      avg_x    <= ax_m;
      avg_y    <= ay_m;
      screen_x <= sx_m;
      screen_y <= sy_m;
    end
  end

endmodule

[src/touch_sample_average_calibrate.sv]
// Top level of the touch sample averaging and calibration block.
// Depends on tsac_pkg, tsac_lane and tsac_merge.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per X/Y pair:
//   pen_down, x_frame, y_frame. The 13-bit sample of each frame (bits 15..3)
//   is added to a saturating per-axis sum in its own lane.
//   After SAMPLES pen-down requests the block produces one result on the
//   output channel (out_valid / out_stall): averages (sum >> 4) and the
//   calibrated screen coordinates. A pen-up request drops the burst and
//   produces an all-zero result on the next cycle.
//   Throughput: non-closing requests are taken one per cycle while the output
//   register is free. The closing request latches the averages as it is
//   taken; its result then passes the clamp and scale multiply, the restoring
//   divider (one quotient bit per cycle) and the load of the output register.
//   in_stall stays high over those states, so no request is taken until the
//   result of the closed burst has been loaded.
//   Stall: a request is taken only while the output register is empty or
//   being taken; a stalled result holds its fields until taken, and a
//   finished computation waits in the load state until the register frees.
//   Reset (rst, synchronous): clears sums, counters, state and out_valid, and
//   restores the calibration to full range, portrait mode.
//   Configuration: cfg_write with cfg_index / cfg_data, only while idle.
module touch_sample_average_calibrate
  import tsac_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 pen_down,
  input  logic [FRAME_W-1:0]   x_frame,
  input  logic [FRAME_W-1:0]   y_frame,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SAMPLE_W-1:0]  avg_x,
  output logic [SAMPLE_W-1:0]  avg_y,
  output logic [SCR_W-1:0]     screen_x,
  output logic [SCR_W-1:0]     screen_y
);

  localparam int CNT_W = $clog2(SAMPLES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

  // Calibration registers.
  logic [SAMPLE_W-1:0] x_cal_min;
  logic [SAMPLE_W-1:0] x_cal_max;
  logic [SAMPLE_W-1:0] y_cal_min;
  logic [SAMPLE_W-1:0] y_cal_max;
  logic                landscape_mode;

  tsac_state_t     state;
  tsac_state_t     state_next;
  logic [CNT_W-1:0]  pair_count;
  logic [STEP_W-1:0] step_count;

  tsac_lane_ctrl_t lane_ctrl;
  tsac_out_ctrl_t  out_ctrl;
  logic            accept;
  logic            out_free;
  logic            burst_last;

  logic [SAMPLE_W-1:0] lane_avg_x;
  logic [SAMPLE_W-1:0] lane_avg_y;
  logic [SCR_W-1:0]    lane_scr_x;
  logic [SCR_W-1:0]    lane_scr_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cal_min      <= '0;
      x_cal_max      <= '1;
      y_cal_min      <= '0;
      y_cal_max      <= '1;
      landscape_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_CAL_MIN: x_cal_min      <= cfg_data;
        REG_X_CAL_MAX: x_cal_max      <= cfg_data;
        REG_Y_CAL_MIN: y_cal_min      <= cfg_data;
        REG_Y_CAL_MAX: y_cal_max      <= cfg_data;
        REG_LANDSCAPE: landscape_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The output register frees at this edge if empty or being taken.
  assign out_free   = !out_valid || !out_stall;
  assign burst_last = pair_count == CNT_LAST;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && pen_down && burst_last) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (step_count == STEP_W'(DIV_STEPS - 1)) state_next = ST_LOAD;
      ST_LOAD: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall            = 1'b1;
    lane_ctrl           = '0;
    out_ctrl            = '0;
    unique case (state)
      ST_IDLE: begin
        in_stall            = !out_free;
        lane_ctrl.acc       = accept && pen_down;
        lane_ctrl.last      = burst_last;
        lane_ctrl.clr       = accept && !pen_down;
        out_ctrl.load_zero  = accept && !pen_down;
      end
      ST_MUL:  lane_ctrl.mul      = 1'b1;
      ST_DIV:  lane_ctrl.step     = 1'b1;
      ST_LOAD: out_ctrl.load_calc = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pair_count <= '0;
      step_count <= '0;
    end else begin
      state <= state_next;
      if (lane_ctrl.clr || (lane_ctrl.acc && burst_last)) begin
        pair_count <= '0;
      end else if (lane_ctrl.acc) begin
        pair_count <= pair_count + 1'b1;
      end
      // advance the divider step count, hold it at zero elsewhere
      step_count <= (state == ST_DIV) ? step_count + 1'b1 : '0;
    end
  end

  tsac_lane u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .sample  (x_frame[FRAME_W-1 -: SAMPLE_W]),
    .cal_min (x_cal_min),
    .cal_max (x_cal_max),
    .span    (X_SPAN),
    .avg     (lane_avg_x),
    .scaled  (lane_scr_x)
  );

  tsac_lane u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lane_ctrl),
    .sample  (y_frame[FRAME_W-1 -: SAMPLE_W]),
    .cal_min (y_cal_min),
    .cal_max (y_cal_max),
    .span    (Y_SPAN),
    .avg     (lane_avg_y),
    .scaled  (lane_scr_y)
  );

  tsac_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (out_ctrl),
    .landscape  (landscape_mode),
    .lane_avg_x (lane_avg_x),
    .lane_avg_y (lane_avg_y),
    .lane_scr_x (lane_scr_x),
    .lane_scr_y (lane_scr_y),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .avg_x      (avg_x),
    .avg_y      (avg_y),
    .screen_x   (screen_x),
    .screen_y   (screen_y)
  );

endmodule

[src/tsac_checker.sv]
// Port-level checker for touch_sample_average_calibrate, bound to the top.
// Depends on tsac_pkg.
module tsac_checker
  import tsac_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                pen_down,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SAMPLE_W-1:0] avg_x,
  input logic [SAMPLE_W-1:0] avg_y,
  input logic [SCR_W-1:0]    screen_x,
  input logic [SCR_W-1:0]    screen_y
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(avg_x) && $stable(avg_y)
      && $stable(screen_x) && $stable(screen_y))
    else $error("stalled result changed");

  a_pen_up: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !pen_down |=> out_valid && avg_x == '0
      && avg_y == '0 && screen_x == '0 && screen_y == '0)
    else $error("pen-up request did not give an all-zero result");

  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && avg_x == '0 && avg_y == '0 |-> screen_x == '0 && screen_y == '0)
    else $error("zero averages with nonzero screen coordinates");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> screen_x <= Y_SPAN && screen_y <= Y_SPAN)
    else $error("screen coordinate out of range");

endmodule

bind touch_sample_average_calibrate tsac_checker u_tsac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .pen_down  (pen_down),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .avg_x     (avg_x),
  .avg_y     (avg_y),
  .screen_x  (screen_x),
  .screen_y  (screen_y)
);

[test/tb_touch_sample_average_calibrate.sv]
// Self-checking testbench for touch_sample_average_calibrate: random and directed
// touch pairs, predicted averages and screen points checked in order. Needs tsac_pkg.
`timescale 1ns / 1ps

module tb_touch_sample_average_calibrate;
  import tsac_pkg::*;

  localparam int BURST_LEN      = SAMPLES_DEFAULT;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int SUM_MAX        = (1 << SUM_W) - 1;
  localparam int SETTLE_CYCLES  = 20;    // lets a closing pair finish in the block
  localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
  localparam int REPORT_LIMIT   = 10;

  // One touch pair request as driven on the input channel.
  typedef struct packed {
    logic               pen;
    logic [FRAME_W-1:0] x_frame;
    logic [FRAME_W-1:0] y_frame;
  } touch_pair_t;

  // One result: averaged raw values and calibrated screen point.
  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_x;
    logic [SAMPLE_W-1:0] avg_y;
    logic [SCR_W-1:0]    screen_x;
    logic [SCR_W-1:0]    screen_y;
  } touch_point_t;

  // DUT inputs, all known from time zero.
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_X_CAL_MIN;
  logic [SAMPLE_W-1:0]  cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 pen_down  = 1'b0;
  logic [FRAME_W-1:0]   x_frame   = '0;
  logic [FRAME_W-1:0]   y_frame   = '0;
  logic                 out_stall = 1'b0;

  // DUT outputs.
  logic                in_stall;
  logic                out_valid;
  logic [SAMPLE_W-1:0] avg_x;
  logic [SAMPLE_W-1:0] avg_y;
  logic [SCR_W-1:0]    screen_x;
  logic [SCR_W-1:0]    screen_y;

  // Pairs waiting to be offered, and points the block still owes us.
  touch_pair_t  pair_queue[$];
  touch_point_t expected_points[$];

  // Shadow of the calibration registers, at their reset values.
  logic [SAMPLE_W-1:0] cal_x_lo  = '0;
  logic [SAMPLE_W-1:0] cal_x_hi  = SAMPLE_W'(SAMPLE_MAX);
  logic [SAMPLE_W-1:0] cal_y_lo  = '0;
  logic [SAMPLE_W-1:0] cal_y_hi  = SAMPLE_W'(SAMPLE_MAX);
  logic                landscape = 1'b0;

  // Shadow of the burst accumulator.
  int               burst_pairs = 0;
  logic [SUM_W-1:0] x_total     = '0;
  logic [SUM_W-1:0] y_total     = '0;

  // Idling knobs (percent of cycles) and hold-off handshake between processes.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int holdoff_req  = 0;
  int holdoff_ack  = 0;
  int holdoff_left = 0;

  // Bookkeeping.
  int mismatches    = 0;
  int pairs_taken   = 0;
  int pen_up_drops  = 0;
  int points_seen   = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  touch_sample_average_calibrate #(
    .SAMPLES(BURST_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pen_down (pen_down),
    .x_frame  (x_frame),
    .y_frame  (y_frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .avg_x    (avg_x),
    .avg_y    (avg_y),
    .screen_x (screen_x),
    .screen_y (screen_y)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturating add of one 13-bit sample into a 17-bit running sum.
  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, logic [SAMPLE_W-1:0] v);
    int r;
    r = int'(s) + int'(v);
    return (r > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(r);
  endfunction

  // Clamp against the limits, else scale by truncating division. When the
  // limits cross or meet, one of the clamps always catches the value.
  function automatic int cal_scale(int v, int lo, int hi, int span);
    if (v <= lo) return 0;
    if (v >= hi) return span;
    return ((v - lo) * span) / (hi - lo);
  endfunction

  // Fold one accepted pair into the burst; queue the point it produces, if any.
  function automatic void average_and_calibrate(touch_pair_t p);
    touch_point_t pt;
    int ax, ay, sx, sy, t;
    pt = '0;
    if (!p.pen) begin
      // Pen lifted: drop the burst and owe an all-zero point.
      burst_pairs = 0;
      x_total = '0;
      y_total = '0;
      pen_up_drops++;
      expected_points.push_back(pt);
      return;
    end
    x_total = sat_sum(x_total, p.x_frame[FRAME_W-1:3]);
    y_total = sat_sum(y_total, p.y_frame[FRAME_W-1:3]);
    burst_pairs++;
    if (burst_pairs < BURST_LEN) return;

    ax = int'(x_total >> AVG_SHIFT);
    ay = int'(y_total >> AVG_SHIFT);
    burst_pairs = 0;
    x_total = '0;
    y_total = '0;

    if (ax == 0 && ay == 0) begin
      // No touch pressure at all: origin, orientation left alone.
      sx = 0;
      sy = 0;
    end else begin
      sx = cal_scale(ax, cal_x_lo, cal_x_hi, X_SPAN);
      sy = int'(Y_SPAN) - cal_scale(ay, cal_y_lo, cal_y_hi, Y_SPAN);
      if (landscape) begin
        // Swap raw axes and rotate the point.
        t = ax; ax = ay; ay = t;
        t = sx; sx = sy; sy = int'(X_SPAN) - t;
      end
    end
    pt.avg_x    = SAMPLE_W'(ax);
    pt.avg_y    = SAMPLE_W'(ay);
    pt.screen_x = SCR_W'(sx);
    pt.screen_y = SCR_W'(sy);
    expected_points.push_back(pt);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued pairs, hold each one steady until it is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    touch_pair_t offer;
    logic        offer_valid;
    logic        load;
    offer_valid = in_valid;
    load = 1'b0;
    offer = '0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        average_and_calibrate('{pen: pen_down, x_frame: x_frame, y_frame: y_frame});
        pairs_taken++;
        offer_valid = 1'b0;
      end
      // Advance to the next pair unless this cycle is an idle gap.
      if (!offer_valid && pair_queue.size() != 0 &&
          int'($urandom_range(99)) >= tx_idle_pct) begin
        offer = pair_queue.pop_front();
        offer_valid = 1'b1;
        load = 1'b1;
      end
      in_valid <= offer_valid;
      if (load) begin
        pen_down <= offer.pen;
        x_frame  <= offer.x_frame;
        y_frame  <= offer.y_frame;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken point against the oldest prediction, drive stall.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("point %0d: %s expected %0d, got %0d", points_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    touch_point_t want;
    logic         stall_next;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("point %0d: unexpected (%0d,%0d) -> (%0d,%0d)",
                     points_seen, avg_x, avg_y, screen_x, screen_y);
        end else begin
          want = expected_points.pop_front();
          check_field("avg_x", want.avg_x, avg_x);
          check_field("avg_y", want.avg_y, avg_y);
          check_field("screen_x", want.screen_x, screen_x);
          check_field("screen_y", want.screen_y, screen_y);
        end
      end
      // Start a long hold-off when asked; count it down here.
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack  = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        stall_next = 1'b1;
      end else begin
        stall_next = int'($urandom_range(99)) < rx_stall_pct;
      end
      out_stall <= stall_next;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d points outstanding",
               quiet_cycles, expected_points.size());
      $display("tb_touch_sample_average_calibrate: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_pair(logic pen, logic [FRAME_W-1:0] xf, logic [FRAME_W-1:0] yf);
    pair_queue.push_back('{pen: pen, x_frame: xf, y_frame: yf});
  endtask

  // Frame carrying a given sample; the three low bits are noise the block drops.
  function automatic logic [FRAME_W-1:0] frame_of(int sample);
    return {SAMPLE_W'(sample), 3'($urandom_range(7))};
  endfunction

  function automatic int clamp_sample(int v);
    return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
  endfunction

  // Full burst around a level per axis; zero jitter gives an exact average.
  task automatic queue_burst(int x_level, int y_level, int jitter);
    int dx, dy;
    for (int i = 0; i < BURST_LEN; i++) begin
      dx = int'($urandom_range(2 * jitter)) - jitter;
      dy = int'($urandom_range(2 * jitter)) - jitter;
      queue_pair(1'b1, frame_of(clamp_sample(x_level + dx)),
                 frame_of(clamp_sample(y_level + dy)));
    end
  endtask

  // Level that often lands on or next to a calibration limit.
  function automatic int pick_level(int lo, int hi);
    case ($urandom_range(9))
      0:       return 0;
      1:       return SAMPLE_MAX;
      2, 3:    return clamp_sample(lo + int'($urandom_range(2)) - 1);
      4, 5:    return clamp_sample(hi + int'($urandom_range(2)) - 1);
      default: return int'($urandom_range(SAMPLE_MAX));
    endcase
  endfunction

  // Mostly well-formed bursts with random content; some noise and cut bursts.
  task automatic queue_random(int count);
    int start, sel, cut, jit;
    start = pair_queue.size();
    while (pair_queue.size() - start < count) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        queue_pair(1'($urandom_range(1)), FRAME_W'($urandom), FRAME_W'($urandom));
      end else if (sel < 18) begin
        cut = $urandom_range(1, BURST_LEN - 1);
        for (int i = 0; i < cut; i++)
          queue_pair(1'b1, FRAME_W'($urandom), FRAME_W'($urandom));
        queue_pair(1'b0, FRAME_W'($urandom), FRAME_W'($urandom));
      end else if (sel < 30) begin
        for (int i = 0; i < BURST_LEN; i++)
          queue_pair(1'b1, FRAME_W'($urandom), FRAME_W'($urandom));
      end else begin
        jit = ($urandom_range(9) < 4) ? 0 : int'($urandom_range(64));
        queue_burst(pick_level(cal_x_lo, cal_x_hi), pick_level(cal_y_lo, cal_y_hi), jit);
      end
    end
  endtask

  // Wait until everything queued was taken and every point came back, then
  // let a pair that owes no point finish inside the block.
  task automatic drain();
    do @(negedge clk);
    while (pair_queue.size() != 0 || in_valid || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(tsac_reg_t idx, logic [SAMPLE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_X_CAL_MIN: cal_x_lo = val;
      REG_X_CAL_MAX: cal_x_hi = val;
      REG_Y_CAL_MIN: cal_y_lo = val;
      REG_Y_CAL_MAX: cal_y_hi = val;
      REG_LANDSCAPE: landscape = val[0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Reprogram the whole calibration while the block is idle.
  task automatic configure(int x_lo, int x_hi, int y_lo, int y_hi, logic land);
    drain();
    write_reg(REG_X_CAL_MIN, SAMPLE_W'(x_lo));
    write_reg(REG_X_CAL_MAX, SAMPLE_W'(x_hi));
    write_reg(REG_Y_CAL_MIN, SAMPLE_W'(y_lo));
    write_reg(REG_Y_CAL_MAX, SAMPLE_W'(y_hi));
    write_reg(REG_LANDSCAPE, SAMPLE_W'(land));
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset calibration, no idling.
    queue_pair(1'b0, 16'hFFFF, 16'h0000);  // pen up with nothing accumulated
    queue_pair(1'b1, 16'hFFFF, 16'h0000);
    queue_pair(1'b1, 16'h0007, 16'hFFF8);
    queue_pair(1'b1, 16'h8000, 16'h7FFF);
    queue_pair(1'b0, 16'h0000, 16'hFFFF);  // pen up mid-burst: drop it
    queue_burst(0, 0, 0);                  // both averages zero: origin
    queue_random(60);

    // Typical portrait calibration, full-scale burst first.
    configure(300, 3900, 250, 3800, 1'b0);
    queue_burst(SAMPLE_MAX, SAMPLE_MAX, 0);
    queue_random(100);

    // Same limits in landscape, sender mostly idle.
    configure(300, 3900, 250, 3800, 1'b1);
    tx_idle_pct = 83;
    queue_random(100);

    // Crossed and equal limits: only the clamps apply. Receiver mostly stalls.
    configure(5000, 2000, 4000, 4000, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    queue_random(100);

    // Full-range extremes, Y limits reversed, landscape; light idling both ways.
    configure(0, SAMPLE_MAX, SAMPLE_MAX, 0, 1'b1);
    tx_idle_pct  = 13;
    rx_stall_pct = 13;
    queue_burst(SAMPLE_MAX, SAMPLE_MAX, 0);
    queue_random(100);

    // One-count-wide windows; hold the receiver off while the sender keeps
    // offering so the result path and then the input back up.
    configure(0, 1, SAMPLE_MAX - 1, SAMPLE_MAX, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    queue_random(100);
    holdoff_req++;

    // Landscape again; sender pauses until all points are back, then resumes
    // against a busy receiver.
    configure(700, 3500, 600, 3600, 1'b1);
    queue_random(50);
    drain();
    rx_stall_pct = 83;
    queue_random(50);

    drain();
    if (expected_points.size() != 0) begin
      mismatches++;
      $display("%0d points never arrived", expected_points.size());
    end

    $display("covered %0d pairs (%0d pen-up drops), %0d points checked, %0d mismatches",
             pairs_taken, pen_up_drops, points_seen, mismatches);
    $display("over 7 calibration settings via %0d register writes", cfg_writes);
    if (mismatches == 0) begin
      $display("tb_touch_sample_average_calibrate: done, clean");
    end else begin
      $display("tb_touch_sample_average_calibrate: done, errors");
    end
    $finish;
  end

endmodule
